// ===== sv/tfn_pkg.sv =====
// package for the triangle face normal block
// shared types, widths and controller state encoding; no dependencies
package tfn_pkg;

    localparam int VertexSlotsDefault = 1024;
    localparam int PosW  = 16;
    localparam int IdxW  = 10;
    localparam int EdgeW = 17;
    localparam int CrsW  = 35;
    localparam int SqW   = 72;
    localparam int RootW = 36;
    localparam int NumW  = 49;
    localparam int NrmW  = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_EDGE,
        ST_CROSS,
        ST_SQ,
        ST_ROOT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic [1:0] rd_sel;
        logic       rd_en;
        logic       edge_en;
        logic       cross_en;
        logic [1:0] sq_step;
        logic       sq_en;
        logic       root_start;
        logic       root_step;
        logic       div_start;
        logic       div_step;
        logic       out_load;
    } tfn_cmd_t;

    typedef struct packed {
        logic root_done;
        logic div_done;
        logic out_busy;
    } tfn_sts_t;

endpackage

// ===== sv/tfn_ctrl.sv =====
// controller state machine for the triangle face normal block
// depends on tfn_pkg
module tfn_ctrl
    import tfn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_func,
    output logic     in_ready,
    input  tfn_sts_t sts,
    output tfn_cmd_t cmd
);

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_func)
                    state_next = ST_RD0;
            end
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_EDGE;
            ST_EDGE: state_next = ST_CROSS;
            ST_CROSS:
            begin
                state_next = ST_SQ;
                cnt_next   = '0;
            end
            ST_SQ:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sts.root_done)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_in = in_valid;
                cmd.rd_en   = in_valid && in_func;
                cmd.rd_sel  = 2'd0;
            end
            ST_RD0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = 2'd1;
            end
            ST_RD1:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = 2'd2;
            end
            ST_EDGE:  cmd.edge_en  = 1'b1;
            ST_CROSS: cmd.cross_en = 1'b1;
            ST_SQ:
            begin
                cmd.sq_en      = 1'b1;
                cmd.sq_step    = cnt_reg;
                cmd.root_start = (cnt_reg == 2'd2);
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cmd.div_start = sts.root_done;
            end
            ST_DIV: cmd.div_step = 1'b1;
            ST_OUT: cmd.out_load = !sts.out_busy;
            default: cmd = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> state_reg == ST_OUT)
        else $error("result load outside output state");
    a_tri_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && in_func) |=> state_reg == ST_RD0)
        else $error("triangle not started");
`endif

endmodule

// ===== sv/tfn_dp.sv =====
// datapath for the triangle face normal block: vertex memory, cross product,
// squared length, bit-pair square root and restoring divider; depends on tfn_pkg
module tfn_dp
    import tfn_pkg::*;
#(
    parameter int VERTEX_SLOTS = VertexSlotsDefault
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tfn_cmd_t               cmd,
    output tfn_sts_t               sts,
    input  logic                   in_func,
    input  logic [IdxW-1:0]        in_slot,
    input  logic signed [PosW-1:0] in_x,
    input  logic signed [PosW-1:0] in_y,
    input  logic signed [PosW-1:0] in_z,
    input  logic [IdxW-1:0]        in_ca,
    input  logic [IdxW-1:0]        in_cb,
    input  logic [IdxW-1:0]        in_cc,
    input  logic                   in_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [NrmW-1:0]        out_nx,
    output logic [NrmW-1:0]        out_ny,
    output logic [NrmW-1:0]        out_nz,
    output logic [IdxW-1:0]        out_ca,
    output logic [IdxW-1:0]        out_cb,
    output logic [IdxW-1:0]        out_cc,
    output logic                   out_degen,
    output logic                   out_last
);

    localparam int AddrW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
    localparam int IdxExtW = (AddrW > IdxW) ? AddrW : IdxW;
    localparam int CmpW = IdxExtW + 1;

    logic [3*PosW-1:0] mem [VERTEX_SLOTS];
    logic [3*PosW-1:0] rd_data_reg;
    logic              rd_oor_reg;

    logic [IdxW-1:0] ca_reg, cb_reg, cc_reg;
    logic            last_reg;
    logic [IdxW-1:0] rd_idx;
    logic [IdxExtW-1:0] rd_ext, wr_ext;
    logic            rd_ok, wr_ok;

    logic signed [PosW-1:0] p_reg [3][3];
    logic signed [EdgeW-1:0] e1_reg [3];
    logic signed [EdgeW-1:0] e2_reg [3];
    logic signed [CrsW-1:0] c_reg [3];
    logic [SqW-1:0] s_reg;

    logic [SqW-1:0]     sq_rem_reg;
    logic [RootW+1:0]   rem_reg;
    logic [RootW-1:0]   root_reg;
    logic [5:0]         rcnt_reg;
    logic               root_busy_reg;

    logic [1:0]         dk_reg;
    logic [NumW-1:0]    num_reg;
    logic [RootW:0]     drem_reg;
    logic [5:0]         dcnt_reg;
    logic               div_busy_reg;
    logic [NrmW-1:0]    q_reg [3];

    logic out_valid_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            2'd0:    rd_idx = in_ca;
            2'd1:    rd_idx = cb_reg;
            default: rd_idx = cc_reg;
        endcase
    end

    assign rd_ext = IdxExtW'(rd_idx);
    assign wr_ext = IdxExtW'(in_slot);
    assign rd_ok  = {1'b0, rd_ext} < CmpW'(VERTEX_SLOTS);
    assign wr_ok  = {1'b0, wr_ext} < CmpW'(VERTEX_SLOTS);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in && !in_func && wr_ok)
            mem[wr_ext[AddrW-1:0]] <= {in_z, in_y, in_x};
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_ext[AddrW-1:0]];
            rd_oor_reg  <= !rd_ok;
        end
    end

    logic [1:0] pslot_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load_in && in_func)
        begin
            ca_reg   <= in_ca;
            cb_reg   <= in_cb;
            cc_reg   <= in_cc;
            last_reg <= in_last;
        end
        pslot_reg <= cmd.rd_sel;
    end

    logic rd_vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else
            rd_vld_reg <= cmd.rd_en;
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            for (int k = 0; k < 3; k++)
                p_reg[pslot_reg][k] <= rd_oor_reg ? '0 : rd_data_reg[k*PosW +: PosW];
        end
        if (cmd.edge_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= EdgeW'(p_reg[1][k]) - EdgeW'(p_reg[0][k]);
                e2_reg[k] <= EdgeW'(p_reg[2][k]) - EdgeW'(p_reg[0][k]);
            end
        end
        if (cmd.cross_en)
        begin
            c_reg[0] <= CrsW'(e1_reg[1] * e2_reg[2]) - CrsW'(e1_reg[2] * e2_reg[1]);
            c_reg[1] <= CrsW'(e1_reg[2] * e2_reg[0]) - CrsW'(e1_reg[0] * e2_reg[2]);
            c_reg[2] <= CrsW'(e1_reg[0] * e2_reg[1]) - CrsW'(e1_reg[1] * e2_reg[0]);
        end
    end

    logic [CrsW-1:0] mag [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            mag[k] = c_reg[k][CrsW-1] ? CrsW'(-c_reg[k]) : CrsW'(c_reg[k]);
    end

    // squared length, one component per cycle; magnitudes stay below 2^34
    logic [CrsW-1:0] sq_in;
    logic [SqW-1:0]  sq_prod;
    always_comb
    begin
        case (cmd.sq_step)
            2'd0:    sq_in = mag[0];
            2'd1:    sq_in = mag[1];
            default: sq_in = mag[2];
        endcase
        sq_prod = SqW'(sq_in) * SqW'(sq_in);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sq_en)
            s_reg <= (cmd.sq_step == 2'd0) ? sq_prod : s_reg + sq_prod;
    end

    // square root by bit pairs, one pair per cycle
    logic [RootW+1:0] r_try, r_rem;
    always_comb
    begin
        r_rem = {rem_reg[RootW-1:0], sq_rem_reg[SqW-1 -: 2]};
        r_try = {root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_busy_reg <= 1'b0;
            rcnt_reg      <= '0;
        end
        else if (cmd.root_start)
        begin
            root_busy_reg <= 1'b1;
            rcnt_reg      <= '0;
        end
        else if (cmd.root_step && root_busy_reg)
        begin
            rcnt_reg <= rcnt_reg + 6'd1;
            if (rcnt_reg == 6'(RootW - 1))
                root_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_start)
        begin
            sq_rem_reg <= s_reg + sq_prod;
            rem_reg    <= '0;
            root_reg   <= '0;
        end
        else if (cmd.root_step && root_busy_reg)
        begin
            sq_rem_reg <= {sq_rem_reg[SqW-3:0], 2'b00};
            if (r_rem >= r_try)
            begin
                rem_reg  <= r_rem - r_try;
                root_reg <= {root_reg[RootW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= r_rem;
                root_reg <= {root_reg[RootW-2:0], 1'b0};
            end
        end
    end

    assign sts.root_done = cmd.root_step && root_busy_reg && rcnt_reg == 6'(RootW - 1);

    // restoring divider, one quotient bit per cycle, three components in turn
    logic [RootW:0] d_sh, d_sub;
    logic           d_ge;
    logic           zero_len;
    assign zero_len = (root_reg == '0);
    always_comb
    begin
        d_sh  = {drem_reg[RootW-1:0], num_reg[NumW-1]};
        d_ge  = d_sh >= {1'b0, root_reg};
        d_sub = d_sh - {1'b0, root_reg};
    end

    logic [NumW-1:0] num_nx;
    logic [NrmW-1:0] qfin;
    assign num_nx = {num_reg[NumW-2:0], d_ge};
    assign qfin   = zero_len ? '0 :
                    (c_reg[dk_reg][CrsW-1] ? NrmW'(-num_nx) : NrmW'(num_nx));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            dcnt_reg     <= '0;
            dk_reg       <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            dcnt_reg     <= '0;
            dk_reg       <= '0;
        end
        else if (cmd.div_step && div_busy_reg)
        begin
            if (dcnt_reg == 6'(NumW - 1))
            begin
                dcnt_reg <= '0;
                dk_reg   <= dk_reg + 2'd1;
                if (dk_reg == 2'd2)
                    div_busy_reg <= 1'b0;
            end
            else
                dcnt_reg <= dcnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg  <= {mag[0], 14'd0};
            drem_reg <= '0;
        end
        else if (cmd.div_step && div_busy_reg)
        begin
            if (dcnt_reg == 6'(NumW - 1))
            begin
                q_reg[dk_reg] <= qfin;
                num_reg  <= (dk_reg == 2'd0) ? {mag[1], 14'd0} : {mag[2], 14'd0};
                drem_reg <= '0;
            end
            else
            begin
                num_reg  <= num_nx;
                drem_reg <= d_ge ? d_sub : d_sh;
            end
        end
    end

    assign sts.div_done = cmd.div_step && div_busy_reg && dcnt_reg == 6'(NumW - 1)
                          && dk_reg == 2'd2;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_nx    <= q_reg[0];
            out_ny    <= q_reg[1];
            out_nz    <= q_reg[2];
            out_ca    <= ca_reg;
            out_cb    <= cb_reg;
            out_cc    <= cc_reg;
            out_degen <= zero_len;
            out_last  <= last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;

`ifndef ASSERT_OFF
    a_root_div_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(root_busy_reg && div_busy_reg))
        else $error("root and divider both busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped");
    a_no_reload: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten");
`endif

endmodule

// ===== sv/triangle_face_normal.sv =====
// triangle face normal top level: a triangle item goes through 3 reads, edge,
// cross, 3 squares, 36 root steps and 3 x 49 divide steps of the shared
// bit-serial divider before its output load; the next item is accepted only
// after that result is loaded, later while an earlier result still waits;
// load items stay in the idle state and give no result
// reset clears control, vertex memory is undefined until written; depends on tfn_pkg
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int VERTEX_SLOTS = VertexSlotsDefault
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_slot, pos_x, pos_y, pos_z, first_corner, second_corner, third_corner
    input  logic [87:0]  s_tdata,
    // func
    input  logic         s_tuser,
    // final_triangle
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // normal_x, normal_y, normal_z, out_corner_a, out_corner_b, out_corner_c, pad
    output logic [79:0]  m_tdata,
    // degenerate
    output logic         m_tuser,
    // final_result
    output logic         m_tlast
);

    tfn_cmd_t cmd;
    tfn_sts_t sts;
    logic [NrmW-1:0] nx, ny, nz;
    logic [IdxW-1:0] oa, ob, oc;

    tfn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tfn_dp #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_func   (s_tuser),
        .in_slot   (s_tdata[9:0]),
        .in_x      (s_tdata[25:10]),
        .in_y      (s_tdata[41:26]),
        .in_z      (s_tdata[57:42]),
        .in_ca     (s_tdata[67:58]),
        .in_cb     (s_tdata[77:68]),
        .in_cc     (s_tdata[87:78]),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_nx    (nx),
        .out_ny    (ny),
        .out_nz    (nz),
        .out_ca    (oa),
        .out_cb    (ob),
        .out_cc    (oc),
        .out_degen (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, oc, ob, oa, nz, ny, nx};

endmodule

// ===== test/triangle_face_normal_tb.sv =====
// testbench for triangle_face_normal: loads vertex positions, submits triangles
// and checks each unit normal against an in-bench fixed-point predictor
// depends on tfn_pkg and triangle_face_normal
`timescale 1ns / 100ps

module triangle_face_normal_tb;
    import tfn_pkg::*;

    localparam int Slots = 1024;
    localparam bit FuncLoad = 1'b0;
    localparam bit FuncTri  = 1'b1;

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [9:0]  ca;
        logic [9:0]  cb;
        logic [9:0]  cc;
        logic        degen;
        logic        last;
    } normal_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    logic signed [15:0] vtx_x [Slots];
    logic signed [15:0] vtx_y [Slots];
    logic signed [15:0] vtx_z [Slots];
    bit                 vtx_written [Slots];
    normal_t            normals_pending [$];
    int                 mismatches;
    bit                 rx_stall_en;

    triangle_face_normal dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #6 clk = ~clk;

    function automatic logic [35:0] isqrt72(logic [71:0] s);
        logic [35:0] root;
        logic [73:0] rem;
        logic [73:0] trial;
        root = '0;
        rem = '0;
        for (int i = 35; i >= 0; i--)
        begin
            rem = (rem << 2) | s[2*i +: 2];
            trial = {root, 2'b01};
            root = root << 1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root[0] = 1'b1;
            end
        end
        return root;
    endfunction

    function automatic normal_t face_normal(logic [9:0] a, logic [9:0] b, logic [9:0] c,
                                            logic last);
        logic signed [63:0] p0 [3];
        logic signed [63:0] p1 [3];
        logic signed [63:0] p2 [3];
        logic signed [63:0] e1 [3];
        logic signed [63:0] e2 [3];
        logic signed [63:0] cr [3];
        logic [71:0]        sq;
        logic [35:0]        len;
        logic [63:0]        mag;
        logic [63:0]        q;
        logic [15:0]        comp [3];
        normal_t            r;
        p0[0] = vtx_x[a]; p0[1] = vtx_y[a]; p0[2] = vtx_z[a];
        p1[0] = vtx_x[b]; p1[1] = vtx_y[b]; p1[2] = vtx_z[b];
        p2[0] = vtx_x[c]; p2[1] = vtx_y[c]; p2[2] = vtx_z[c];
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = p1[k] - p0[k];
            e2[k] = p2[k] - p0[k];
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        sq = '0;
        for (int k = 0; k < 3; k++)
        begin
            mag = cr[k] < 0 ? -cr[k] : cr[k];
            sq = sq + 72'(mag) * 72'(mag);
        end
        len = isqrt72(sq);
        for (int k = 0; k < 3; k++)
        begin
            mag = cr[k] < 0 ? -cr[k] : cr[k];
            q = (len != 0) ? (mag << 14) / 64'(len) : 64'd0;
            comp[k] = cr[k] < 0 ? 16'(-q) : 16'(q);
        end
        r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2];
        r.ca = a; r.cb = b; r.cc = c;
        r.degen = (len == 0);
        r.last = last;
        return r;
    endfunction

    task automatic send_item(bit func, logic [9:0] slot, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, logic [9:0] a, logic [9:0] b, logic [9:0] c,
                             bit last);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata <= {c, b, a, z, y, x, slot};
        s_tuser <= func;
        s_tlast <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (func == FuncLoad)
        begin
            vtx_x[slot] = x;
            vtx_y[slot] = y;
            vtx_z[slot] = z;
            vtx_written[slot] = 1'b1;
        end
        else
            normals_pending.push_back(face_normal(a, b, c, last));
        @(negedge clk);
    endtask

    task automatic load_vertex(logic [9:0] slot, logic [15:0] x, logic [15:0] y,
                               logic [15:0] z);
        send_item(FuncLoad, slot, x, y, z, 10'($urandom), 10'($urandom), 10'($urandom),
                  1'($urandom));
    endtask

    task automatic send_triangle(logic [9:0] a, logic [9:0] b, logic [9:0] c, bit last);
        send_item(FuncTri, 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  a, b, c, last);
    endtask

    function automatic logic [9:0] written_slot();
        logic [9:0] s;
        do s = 10'($urandom_range(0, Slots - 1)); while (!vtx_written[s]);
        return s;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (normals_pending.size() != 0) @(negedge clk);
    endtask

    task automatic test_directed();
        load_vertex(0, 16'h0000, 16'h0000, 16'h0000);
        load_vertex(1, 16'h0100, 16'h0000, 16'h0000);
        load_vertex(2, 16'h0000, 16'h0100, 16'h0000);
        load_vertex(3, 16'h7fff, 16'h7fff, 16'h7fff);
        load_vertex(4, 16'h8000, 16'h8000, 16'h8000);
        load_vertex(5, 16'h7fff, 16'h8000, 16'h7fff);
        load_vertex(1023, 16'h8000, 16'h7fff, 16'h0001);
        load_vertex(6, 16'hffff, 16'h0002, 16'h8000);
        send_triangle(0, 1, 2, 0);
        send_triangle(0, 2, 1, 1);
        send_triangle(0, 0, 0, 0);
        send_triangle(1, 1, 2, 0);
        send_triangle(0, 3, 4, 0);
        send_triangle(3, 4, 5, 0);
        send_triangle(4, 5, 1023, 0);
        send_triangle(1023, 3, 5, 1);
        send_triangle(6, 4, 3, 0);
        send_triangle(5, 1023, 6, 0);
        send_triangle(2, 2, 2, 1);
        send_triangle(1023, 1023, 4, 0);
    endtask

    task automatic test_random_mesh(int count);
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        x = 16'($urandom);
                        y = 16'($urandom);
                        z = 16'($urandom);
                    end
                    1:
                    begin
                        x = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                        y = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                        z = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    end
                    default:
                    begin
                        x = 16'($signed($urandom_range(0, 1024)) - 512);
                        y = 16'($signed($urandom_range(0, 1024)) - 512);
                        z = 16'($signed($urandom_range(0, 1024)) - 512);
                    end
                endcase
                load_vertex(10'($urandom_range(0, Slots - 1)), x, y, z);
            end
            else
                send_triangle(written_slot(), written_slot(), written_slot(),
                              1'($urandom));
        end
    endtask

    task automatic test_pause_then_burst();
        wait_drained();
        rx_stall_en = 1'b0;
        for (int i = 0; i < 20; i++)
            send_triangle(written_slot(), written_slot(), written_slot(), i == 19);
        wait_drained();
        rx_stall_en = 1'b1;
    endtask

    // result side: random stalls if enabled, per-field compare to oldest prediction
    initial
    begin
        normal_t got;
        normal_t want;
        int      stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = rx_stall_en ? $urandom_range(0, 7) : 0;
            if (rx_stall_en && $urandom_range(0, 3) == 0)
                stall = 0;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            got.nx = m_tdata[15:0];
            got.ny = m_tdata[31:16];
            got.nz = m_tdata[47:32];
            got.ca = m_tdata[57:48];
            got.cb = m_tdata[67:58];
            got.cc = m_tdata[77:68];
            got.degen = m_tuser;
            got.last = m_tlast;
            if (normals_pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected normal item %h", got);
            end
            else
            begin
                want = normals_pending.pop_front();
                if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
                    got.ca !== want.ca || got.cb !== want.cb || got.cc !== want.cc ||
                    got.degen !== want.degen || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("normal mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        mismatches = 0;
        rx_stall_en = 1'b1;
        for (int i = 0; i < Slots; i++)
            vtx_written[i] = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_mesh(500);
        test_pause_then_burst();
        test_random_mesh(560);
        wait_drained();
        repeat (200) @(negedge clk);
        if (mismatches == 0 && normals_pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tfn_pkg.sv
sv/tfn_ctrl.sv
sv/tfn_dp.sv
sv/triangle_face_normal.sv
test/triangle_face_normal_tb.sv
